// ===== rtl/core/dil3_pkg.sv =====
// Package for the 3x3 box-sum threshold dilation block.
// Holds geometry limits, register map codes and the pipeline item types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dil3_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4095;
    localparam int MIN_DIM     = 3;

    localparam int PIX_W       = 8;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 12;
    localparam int REG_W       = 12;
    localparam int CSUM_W      = 10;
    localparam int WSUM_W      = 12;

    localparam int OQ_DEPTH    = 4;
    localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W    = OQ_PTR_W + 1;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Register index codes, taken from paddr[3:2]
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_SUM_THRESHOLD = 2'd2;

    localparam logic [REG_W-1:0] RST_IMAGE_WIDTH   = REG_W'(640);
    localparam logic [REG_W-1:0] RST_IMAGE_HEIGHT  = REG_W'(480);
    localparam logic [REG_W-1:0] RST_SUM_THRESHOLD = '0;

    // Item between the accept stage and the memory-read stage
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               emit;
        logic               last;
        logic               fwd;
        logic [2*PIX_W-1:0] fwd_data;
    } t_s1;

    // Result item in the output queue
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             value;
        logic             last;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/core/dilate_3x3_box_sum_threshold_top.sv =====
// Top level of the 3x3 box-sum threshold dilation block.
// Path: an accepted pixel is registered into the read stage, then its result into the output queue.
// Throughput: one pixel per cycle; the line memory is read and written once per item.
// Input ready drops only when the 4-entry output queue is near full.
// Reset (synchronous, active low) clears counters, column sums, queue and registers;
// the line memory is not cleared and is refilled by the first two rows.
`timescale 1ns / 1ps
`default_nettype none

module dilate_3x3_box_sum_threshold_top
    import dil3_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // APB configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    // Pixel stream in
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] pixel
    input  wire logic                  s_axis_tuser,   // [0] frame_start

    // Result stream out
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [23:0]           m_axis_tdata,   // [0] out_value, [12:1] out_row,
                                                       // [23:13] out_col
    output logic                       m_axis_tlast    // out_last
);

    // ---------------- configuration registers ----------------
    logic [REG_W-1:0] r_width, r_height, r_thresh;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
            r_thresh <= RST_SUM_THRESHOLD;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:   r_width  <= pwdata[REG_W-1:0];
                REG_IMAGE_HEIGHT:  r_height <= pwdata[REG_W-1:0];
                REG_SUM_THRESHOLD: r_thresh <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:   prdata = APB_DATA_W'(r_width);
            REG_IMAGE_HEIGHT:  prdata = APB_DATA_W'(r_height);
            REG_SUM_THRESHOLD: prdata = APB_DATA_W'(r_thresh);
            default:           prdata = '0;
        endcase
    end

    // Clamped geometry, minus one
    logic [REG_W-1:0] w_cl, h_cl, wm1, hm1;

    always_comb begin
        if (r_width < REG_W'(MIN_DIM))          w_cl = REG_W'(MIN_DIM);
        else if (r_width > REG_W'(MAX_WIDTH))   w_cl = REG_W'(MAX_WIDTH);
        else                                    w_cl = r_width;
        if (r_height < REG_W'(MIN_DIM))         h_cl = REG_W'(MIN_DIM);
        else if (r_height > REG_W'(MAX_HEIGHT)) h_cl = REG_W'(MAX_HEIGHT);
        else                                    h_cl = r_height;
        wm1 = w_cl - REG_W'(1);
        hm1 = h_cl - REG_W'(1);
    end

    // ---------------- accept stage: position counters ----------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] cur_c, n_col;
    logic [ROW_W-1:0] cur_r, n_row;
    logic             s_acc;
    logic             cur_emit, cur_last;

    logic             r_s1_v;
    t_s1              r_s1, n_s1;
    logic [OQ_CNT_W-1:0] r_cnt;

    // Room for every item that may still land in the queue
    assign s_axis_tready = (r_cnt + OQ_CNT_W'(r_s1_v)) < OQ_CNT_W'(OQ_DEPTH);
    assign s_acc         = s_axis_tvalid & s_axis_tready;

    always_comb begin
        cur_c = s_axis_tuser ? '0 : r_col;
        cur_r = s_axis_tuser ? '0 : r_row;
        cur_emit = (cur_r >= ROW_W'(2)) && (cur_r <= hm1) &&
                   (cur_c >= COL_W'(2)) && ({1'b0, cur_c} <= wm1);
        cur_last = (cur_r == hm1) && ({1'b0, cur_c} == wm1);
        if ({1'b0, cur_c} >= wm1) begin
            n_col = '0;
            n_row = (cur_r >= hm1) ? '0 : cur_r + ROW_W'(1);
        end else begin
            n_col = cur_c + COL_W'(1);
            n_row = cur_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (s_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- line memory: {two rows up, one row up} ----------------
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_mem_q;
    logic [2*PIX_W-1:0] rd_data, wr_data;

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            mem[r_s1.col] <= wr_data;
        end
        if (s_acc) begin
            r_mem_q <= mem[cur_c];
        end
    end

    // Forward the write of the same edge when the new item reads that column
    always_comb begin
        n_s1.pix      = s_axis_tdata;
        n_s1.row      = cur_r;
        n_s1.col      = cur_c;
        n_s1.emit     = cur_emit;
        n_s1.last     = cur_last;
        n_s1.fwd      = r_s1_v && (r_s1.col == cur_c);
        n_s1.fwd_data = wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= s_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- read stage: column and window sums ----------------
    logic [CSUM_W-1:0] r_psum0, r_psum1;
    logic [CSUM_W-1:0] colsum;
    logic [WSUM_W-1:0] winsum;
    t_res              res;
    logic              push;

    always_comb begin
        rd_data = r_s1.fwd ? r_s1.fwd_data : r_mem_q;
        wr_data = {rd_data[PIX_W-1:0], r_s1.pix};
        colsum  = CSUM_W'(rd_data[2*PIX_W-1:PIX_W]) + CSUM_W'(rd_data[PIX_W-1:0]) +
                  CSUM_W'(r_s1.pix);
        winsum  = WSUM_W'(colsum) + WSUM_W'(r_psum0) + WSUM_W'(r_psum1);
        res.value = winsum > r_thresh;
        res.row   = r_s1.row - ROW_W'(1);
        res.col   = r_s1.col - COL_W'(1);
        res.last  = r_s1.last;
        push      = r_s1_v & r_s1.emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum0 <= '0;
            r_psum1 <= '0;
        end else if (r_s1_v) begin
            r_psum1 <= r_psum0;
            r_psum0 <= colsum;
        end
    end

    // ---------------- output queue ----------------
    t_res                r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wp, r_rp;
    logic                pop;
    t_res                head;

    assign head          = r_oq[r_rp];
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {head.col, head.row, head.value};
    assign m_axis_tlast  = head.last;
    assign pop           = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + OQ_PTR_W'(1);
            if (pop)  r_rp <= r_rp + OQ_PTR_W'(1);
            r_cnt <= r_cnt + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_oq[r_wp] <= res;
        end
    end

    // ---------------- assertions ----------------
    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue overflow");

    a_oq_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt < OQ_CNT_W'(OQ_DEPTH)) || pop)
        else $error("push into full output queue");

    a_acc_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_s1_v)
        else $error("accepted item lost before memory stage");

    a_out_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (head.row != '0) && (head.col != '0))
        else $error("border center emitted");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for dilate_3x3_box_sum_threshold_top: streams pixel frames,
// predicts every thresholded 3x3 window result and checks the result stream field by field.
// Depends on dil3_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb;
    import dil3_pkg::*;

    localparam int N_RANDOM_ITEMS = 1550;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 60;
    localparam int CYCLE_LIMIT    = 600_000;
    localparam int BIG_PHASE      = 1;
    localparam int TALL_PHASE     = 3;
    localparam int SHRINK_PHASE   = 4;

    typedef enum logic {ROW_PIXEL, ROW_REG} t_row_kind;
    typedef enum int {PIX_UNIFORM, PIX_SPARSE, PIX_BRIGHT} t_pix_mode;

    typedef struct {
        t_row_kind        kind;
        logic [1:0]       reg_idx;
        logic [REG_W-1:0] reg_val;
        logic [PIX_W-1:0] pix;
        logic             fs;
        logic             typed;
        t_res             res;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] pixel
    logic                  s_axis_tuser;   // [0] frame_start
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;   // [0] out_value, [12:1] out_row, [23:13] out_col
    logic                  m_axis_tlast;   // out_last

    // Window predictor state
    bit   [PIX_W-1:0]  line_above_q [MAX_WIDTH];
    bit   [PIX_W-1:0]  line_two_q   [MAX_WIDTH];
    bit   [CSUM_W-1:0] csum_prev1;
    bit   [CSUM_W-1:0] csum_prev2;
    int unsigned       col_cnt;
    int unsigned       row_cnt;
    logic [REG_W-1:0]  cfg_width;
    logic [REG_W-1:0]  cfg_height;
    logic [REG_W-1:0]  cfg_thresh;

    t_res              window_q[$];
    t_stim_row         stim_tab[$];
    int unsigned       err_cnt = 0;
    int unsigned       cyc = 0;
    int unsigned       snd_max_gap;
    int unsigned       rcv_max_stall;
    bit                rx_hold_req;

    dilate_3x3_box_sum_threshold_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) cyc <= cyc + 1;

    initial begin : watchdog
        wait (cyc >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned eff_dim(input logic [REG_W-1:0] v, input int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_res mk_res(input logic value, input int unsigned row,
                                    input int unsigned col, input logic last);
        t_res res;
        res.value = value;
        res.row   = ROW_W'(row);
        res.col   = COL_W'(col);
        res.last  = last;
        return res;
    endfunction

    function automatic void tab_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
        stim_tab.push_back('{ROW_REG, idx, val, '0, 1'b0, 1'b0, '0});
    endfunction

    function automatic void tab_pix(input logic [PIX_W-1:0] pix, input logic fs,
                                    input logic typed, input t_res res);
        stim_tab.push_back('{ROW_PIXEL, '0, '0, pix, fs, typed, res});
    endfunction

    function automatic logic [PIX_W-1:0] gen_pixel(input t_pix_mode mode);
        case (mode)
            PIX_UNIFORM: return PIX_W'($urandom);
            PIX_SPARSE:  return ($urandom_range(9) == 0) ? PIX_W'($urandom) : '0;
            default:     return PIX_W'($urandom_range(255, 192));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        err_cnt++;
    endtask

    // Advance the window state by one accepted pixel and queue its result, if any.
    task automatic predict_window(input logic [PIX_W-1:0] pix, input logic fs,
                                  input logic typed, input t_res typed_res);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned colsum;
        int unsigned win;
        w = eff_dim(cfg_width, MAX_WIDTH);
        h = eff_dim(cfg_height, MAX_HEIGHT);
        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        r = row_cnt;
        c = col_cnt;
        if (c < MAX_WIDTH) begin
            colsum = line_two_q[c] + line_above_q[c] + pix;
            line_two_q[c]   = line_above_q[c];
            line_above_q[c] = pix;
        end else begin
            colsum = pix;
        end
        if (typed) begin
            window_q.push_back(typed_res);
        end else if (r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1) begin
            win = colsum + csum_prev1 + csum_prev2;
            window_q.push_back(mk_res(win > cfg_thresh, r - 1, c - 1,
                                      r == h - 1 && c == w - 1));
        end
        csum_prev2 = csum_prev1;
        csum_prev1 = CSUM_W'(colsum);
        if (c >= w - 1) begin
            col_cnt = 0;
            row_cnt = (r >= h - 1) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                              input logic typed, input t_res typed_res);
        int unsigned gap;
        gap = $urandom_range(snd_max_gap);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= pix;
        s_axis_tuser  <= fs;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_window(pix, fs, typed, typed_res);
    endtask

    // Stop offering pixels until every queued result is out and the pipe is empty.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (window_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [REG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {20'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:   cfg_width  = val;
            REG_IMAGE_HEIGHT:  cfg_height = val;
            REG_SUM_THRESHOLD: cfg_thresh = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    initial begin : result_sink
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            stall = $urandom_range(rcv_max_stall);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (window_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item row %0d col %0d",
                                          m_axis_tdata[12:1], m_axis_tdata[23:13]));
            end else begin
                want = window_q.pop_front();
                if (m_axis_tdata[0] !== want.value)
                    report_mismatch($sformatf("out_value %b, want %b at row %0d col %0d",
                                              m_axis_tdata[0], want.value, want.row, want.col));
                if (m_axis_tdata[12:1] !== want.row)
                    report_mismatch($sformatf("out_row %0d, want %0d",
                                              m_axis_tdata[12:1], want.row));
                if (m_axis_tdata[23:13] !== want.col)
                    report_mismatch($sformatf("out_col %0d, want %0d",
                                              m_axis_tdata[23:13], want.col));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("out_last %b, want %b at row %0d col %0d",
                                              m_axis_tlast, want.last, want.row, want.col));
            end
        end
    end

    initial begin : stimulus
        int unsigned p;
        int unsigned k;
        int unsigned nfr;
        int unsigned len;
        int unsigned new_w;
        int unsigned new_h;
        int unsigned new_t;
        int unsigned rand_items;
        bit          start_fs;
        bit          fs;
        t_pix_mode   mode;

        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        snd_max_gap   = 5;
        rcv_max_stall = 5;
        rx_hold_req   = 1'b0;
        cfg_width     = RST_IMAGE_WIDTH;
        cfg_height    = RST_IMAGE_HEIGHT;
        cfg_thresh    = RST_SUM_THRESHOLD;
        csum_prev1    = '0;
        csum_prev2    = '0;
        col_cnt       = 0;
        row_cnt       = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest frame: three bright rows over a dark one, threshold one below full scale
        tab_reg(REG_IMAGE_WIDTH, 3);
        tab_reg(REG_IMAGE_HEIGHT, 4);
        tab_reg(REG_SUM_THRESHOLD, 2294);
        for (int i = 0; i < 12; i++)
            tab_pix((i < 9) ? 8'hFF : 8'h00, i == 0, i == 8 || i == 11,
                    (i == 8) ? mk_res(1, 1, 1, 0) : mk_res(0, 2, 1, 1));
        // Threshold zero, aborted frame, then an all-dark frame with one lit pixel
        tab_reg(REG_SUM_THRESHOLD, 0);
        tab_pix(8'h5A, 1'b1, 1'b0, '0);
        tab_pix(8'hA5, 1'b0, 1'b0, '0);
        for (int i = 0; i < 12; i++)
            tab_pix((i == 11) ? 8'h01 : 8'h00, i == 0, i == 8 || i == 11,
                    (i == 8) ? mk_res(0, 1, 1, 0) : mk_res(1, 2, 1, 1));

        foreach (stim_tab[i]) begin
            if (stim_tab[i].kind == ROW_REG) begin
                drain_results();
                reg_write(stim_tab[i].reg_idx, stim_tab[i].reg_val);
            end else begin
                send_pixel(stim_tab[i].pix, stim_tab[i].fs, stim_tab[i].typed, stim_tab[i].res);
            end
        end

        p = 0;
        rand_items = 0;
        while (p <= SHRINK_PHASE || rand_items < N_RANDOM_ITEMS) begin
            case (p)
                0: begin
                    new_w = 12;
                    new_h = 6;
                end
                BIG_PHASE: begin
                    new_w = 4095;
                    new_h = 3;
                end
                TALL_PHASE: begin
                    new_w = 3;
                    new_h = 4095;
                end
                SHRINK_PHASE: begin
                    // set the width to three or below, pull the height under the current row
                    new_w = $urandom_range(3);
                    new_h = $urandom_range(7, 3);
                end
                default: begin
                    k = $urandom_range(9);
                    new_w = (k == 0) ? $urandom_range(2) :
                            (k == 1) ? $urandom_range(24, 10) : $urandom_range(9, 3);
                    k = $urandom_range(9);
                    new_h = (k == 0) ? $urandom_range(2) : $urandom_range(7, 3);
                end
            endcase
            k = $urandom_range(7);
            new_t = (k == 0) ? 0 : (k == 1) ? 4095 :
                    (k == 2) ? $urandom_range(4095) : $urandom_range(2300);

            // A wider row would read line entries not yet written: restart the frame
            start_fs = (eff_dim(REG_W'(new_w), MAX_WIDTH) > eff_dim(cfg_width, MAX_WIDTH))
                       || (p != SHRINK_PHASE && $urandom_range(3) != 0);

            drain_results();
            reg_write(REG_IMAGE_WIDTH, REG_W'(new_w));
            reg_write(REG_IMAGE_HEIGHT, REG_W'(new_h));
            reg_write(REG_SUM_THRESHOLD, REG_W'(new_t));

            if (p == 0) begin
                snd_max_gap   = 0;
                rcv_max_stall = 0;
                rx_hold_req   = 1'b1;
            end else begin
                k = $urandom_range(3);
                snd_max_gap = (k == 0) ? 0 : (k == 1) ? 1 : 5;
                k = $urandom_range(3);
                rcv_max_stall = (k == 0) ? 0 : (k == 1) ? 1 : 5;
            end

            nfr = (p == BIG_PHASE || p == TALL_PHASE) ? 1 : $urandom_range(3, 1);
            for (int f = 0; f < nfr; f++) begin
                mode = t_pix_mode'($urandom_range(2));
                len  = eff_dim(cfg_width, MAX_WIDTH) * eff_dim(cfg_height, MAX_HEIGHT);
                if (p == TALL_PHASE || p == BIG_PHASE)
                    len = 120;
                else if ($urandom_range(4) == 0)
                    len = $urandom_range(len - 1, 1);
                for (int i = 0; i < len; i++) begin
                    if (i == 0)
                        fs = (f == 0) ? start_fs : ($urandom_range(3) != 0);
                    else
                        fs = (p != BIG_PHASE && $urandom_range(63) == 0);
                    send_pixel(gen_pixel(mode), fs, 1'b0, '0);
                    rand_items++;
                    if (p == BIG_PHASE && i == len / 2) drain_results();
                end
            end
            p++;
        end

        drain_results();
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
